### rtl/core/tak_pkg.sv
package tak_pkg;

  // Fixed widths of the data path
  localparam int DATA_W = 32;            // angle-domain words, Q16.16
  localparam int SUM_W  = 48;            // exact sums before saturation
  localparam int A_W    = 36;            // multiplier operand A, signed
  localparam int B_W    = 34;            // multiplier operand B, signed
  localparam int P_W    = A_W + B_W;     // unsigned magnitude product
  localparam int Q_SH   = 30;            // Q2.30 scaling
  localparam int DIV_N  = 32;            // quotient bits per gain
  localparam int CNT_W  = $clog2(DIV_N);
  localparam int ADDR_W = 4;

  // Register map (word index)
  localparam logic [1:0] REG_ANGLE_NOISE = 2'd0;
  localparam logic [1:0] REG_BIAS_NOISE  = 2'd1;
  localparam logic [1:0] REG_MEAS_NOISE  = 2'd2;
  localparam logic [1:0] REG_TIME_STEP   = 2'd3;

  // Register reset values, Q2.30
  localparam logic [31:0] RST_ANGLE_NOISE = 32'd4294967;
  localparam logic [31:0] RST_BIAS_NOISE  = 32'd32212;
  localparam logic [31:0] RST_MEAS_NOISE  = 32'd536870912;
  localparam logic [31:0] RST_TIME_STEP   = 32'd1073742;
  localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;

  localparam logic signed [31:0] S32_MAX = 32'sh7fffffff;
  localparam logic signed [31:0] S32_MIN = 32'sh80000000;

  typedef struct packed {
    logic [31:0] angle_noise;
    logic [31:0] bias_noise;
    logic [31:0] meas_noise;
    logic [31:0] time_step;
  } cfg_t;

  // Multiplier passes, in issue order
  typedef enum logic [3:0] {
    OP_ANG, OP_P00, OP_P01, OP_P11,
    OP_C00, OP_C01, OP_C10, OP_C11,
    OP_AE,  OP_BE
  } op_t;

  typedef enum logic [3:0] {
    S_IDLE, S_LD, S_MUL, S_WB, S_PREP,
    S_DIV_INIT, S_DIV_RUN, S_DIV_END, S_FIN
  } state_t;

  typedef struct packed {
    logic load_in;
    logic ld;
    logic mul;
    logic wb;
    op_t  op;
    logic prep;
    logic div_init;
    logic div_step;
    logic div_wb;
    logic div_sel;   // 0: gain from P00, 1: gain from P10
    logic fin;
  } cmd_t;

  typedef struct packed {
    logic div_last;
  } status_t;

  // Saturate an exact sum to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [SUM_W-1:0] v);
    logic signed [31:0] r;
    if (v > SUM_W'(S32_MAX)) r = S32_MAX;
    else if (v < SUM_W'(S32_MIN)) r = S32_MIN;
    else r = v[31:0];
    return r;
  endfunction

endpackage

### rtl/core/tak_regs.sv
module tak_regs (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [tak_pkg::ADDR_W-1:0]   cfg_paddr,
  input  logic [31:0]                  cfg_pwdata,
  output logic [31:0]                  cfg_prdata,
  output logic                         cfg_pready,
  output tak_pkg::cfg_t                cfg
);
  import tak_pkg::*;

  cfg_t cfg_r;
  logic wr_en;
  logic [1:0] idx;

  assign idx        = cfg_paddr[3:2];
  assign cfg_pready = 1'b1;
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;
  assign cfg        = cfg_r;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.angle_noise <= RST_ANGLE_NOISE;
      cfg_r.bias_noise  <= RST_BIAS_NOISE;
      cfg_r.meas_noise  <= RST_MEAS_NOISE;
      cfg_r.time_step   <= RST_TIME_STEP;
    end else if (wr_en) begin
      unique case (idx)
        REG_ANGLE_NOISE: cfg_r.angle_noise <= cfg_pwdata;
        REG_BIAS_NOISE:  cfg_r.bias_noise  <= cfg_pwdata;
        REG_MEAS_NOISE:  cfg_r.meas_noise  <= cfg_pwdata;
        REG_TIME_STEP:   cfg_r.time_step   <= cfg_pwdata;
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    unique case (idx)
      REG_ANGLE_NOISE: cfg_prdata = cfg_r.angle_noise;
      REG_BIAS_NOISE:  cfg_prdata = cfg_r.bias_noise;
      REG_MEAS_NOISE:  cfg_prdata = cfg_r.meas_noise;
      REG_TIME_STEP:   cfg_prdata = cfg_r.time_step;
      default:         cfg_prdata = '0;
    endcase
  end

endmodule

### rtl/core/tak_dp.sv
module tak_dp (
  input  logic             clk,
  input  logic             rst_n,
  input  tak_pkg::cmd_t    cmd,
  input  tak_pkg::cfg_t    cfg,
  input  logic [63:0]      in_tdata,   // [31:0] accel_angle, [63:32] gyro_rate
  output tak_pkg::status_t status,
  output logic [63:0]      out_tdata   // [31:0] filtered_angle, [63:32] corrected_rate
);
  import tak_pkg::*;

  // Filter state
  logic signed [31:0] angle_r, bias_r, p00_r, p01_r, p10_r, p11_r;
  // Beat latch and per-item scratch
  logic signed [31:0] meas_r, rate_r, err_r, t0_r, t1_r, k0_r, k1_r;
  logic signed [33:0] e_r;
  // Shared multiplier
  logic [A_W-1:0] a_mag_r;
  logic [B_W-1:0] b_mag_r;
  logic           neg_r, pneg_r;
  logic [P_W-1:0] prod_r;
  // Divider
  logic [34:0]      rem_r;
  logic [31:0]      dnum_r, q_r;
  logic [CNT_W-1:0] cnt_r;
  logic             dneg_r, dzero_r, dovf_r;
  // Result
  logic signed [31:0] out_ang_r, out_rate_r;

  logic signed [SUM_W-1:0] opa, opb, m, d0, dt_s;
  logic signed [31:0]      rb;
  logic [P_W:0]            rnd;
  logic signed [31:0]      dp;
  logic [31:0]             pm;
  logic [34:0]             dtry, e_u;
  logic signed [31:0]      kq;

  assign dt_s = SUM_W'($signed({1'b0, cfg.time_step}));
  assign rb   = sat32(SUM_W'(rate_r) - SUM_W'(bias_r));
  assign d0   = SUM_W'($signed({1'b0, cfg.angle_noise})) - SUM_W'(p01_r) - SUM_W'(p10_r);

  // Operand selection
  always_comb begin
    unique case (cmd.op)
      OP_ANG:  begin opa = SUM_W'(rb);     opb = dt_s; end
      OP_P00:  begin opa = d0;             opb = dt_s; end
      OP_P01:  begin opa = -SUM_W'(p11_r); opb = dt_s; end
      OP_P11:  begin opa = SUM_W'($signed({1'b0, cfg.bias_noise})); opb = dt_s; end
      OP_C00:  begin opa = SUM_W'(k0_r);   opb = SUM_W'(t0_r); end
      OP_C01:  begin opa = SUM_W'(k0_r);   opb = SUM_W'(t1_r); end
      OP_C10:  begin opa = SUM_W'(k1_r);   opb = SUM_W'(t0_r); end
      OP_C11:  begin opa = SUM_W'(k1_r);   opb = SUM_W'(t1_r); end
      OP_AE:   begin opa = SUM_W'(err_r);  opb = SUM_W'(k0_r); end
      OP_BE:   begin opa = SUM_W'(err_r);  opb = SUM_W'(k1_r); end
      default: begin opa = '0;             opb = '0; end
    endcase
  end

  // Rounded product, half away from zero
  assign rnd = {1'b0, prod_r} + ((P_W+1)'(1) << (Q_SH - 1));
  assign m   = pneg_r ? -SUM_W'($signed({1'b0, rnd[P_W:Q_SH]}))
                      :  SUM_W'($signed({1'b0, rnd[P_W:Q_SH]}));

  // Divider operands
  assign dp   = cmd.div_sel ? p10_r : p00_r;
  assign pm   = dp[31] ? 32'(-dp) : 32'(dp);
  assign e_u  = {1'b0, e_r};
  assign dtry = {rem_r[33:0], dnum_r[31]};

  // Signed, saturated gain
  always_comb begin
    priority if (dzero_r)       kq = '0;
    else if (dovf_r)            kq = dneg_r ? S32_MIN : S32_MAX;
    else if (dneg_r)            kq = (q_r > 32'h80000000) ? S32_MIN : 32'(-q_r);
    else                        kq = q_r[31] ? S32_MAX : $signed(q_r);
  end

  // Multiplier pipeline
  always_ff @(posedge clk) begin
    if (cmd.ld) begin
      a_mag_r <= opa[A_W-1] ? A_W'(-opa) : A_W'(opa);
      b_mag_r <= opb[B_W-1] ? B_W'(-opb) : B_W'(opb);
      neg_r   <= opa[A_W-1] ^ opb[B_W-1];
    end
    if (cmd.mul) begin
      prod_r <= P_W'(a_mag_r) * P_W'(b_mag_r);
      pneg_r <= neg_r;
    end
  end

  // Input latch, scratch and divider
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas_r <= in_tdata[31:0];
      rate_r <= in_tdata[63:32];
    end
    if (cmd.prep) begin
      err_r <= sat32(SUM_W'(meas_r) - SUM_W'(angle_r));
      e_r   <= 34'($signed({1'b0, cfg.meas_noise})) + 34'(p00_r);
      t0_r  <= p00_r;
      t1_r  <= p01_r;
    end
    if (cmd.div_init) begin
      rem_r   <= {5'b0, pm[31:2]};
      dnum_r  <= {pm[1:0], 30'b0};
      q_r     <= '0;
      cnt_r   <= CNT_W'(DIV_N - 1);
      dneg_r  <= dp[31];
      dzero_r <= e_r[33] || (e_r == '0);
      dovf_r  <= {4'b0, pm} >= {e_r[33:0], 2'b00};
    end else if (cmd.div_step) begin
      if (dtry >= e_u) begin
        rem_r <= dtry - e_u;
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= dtry;
        q_r   <= {q_r[30:0], 1'b0};
      end
      dnum_r <= {dnum_r[30:0], 1'b0};
      cnt_r  <= cnt_r - CNT_W'(1);
    end
    if (cmd.div_wb) begin
      if (cmd.div_sel) k1_r <= kq;
      else             k0_r <= kq;
    end
    if (cmd.fin) begin
      out_ang_r  <= angle_r;
      out_rate_r <= rb;
    end
  end

  // Filter state write-back
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_r <= '0;
      bias_r  <= '0;
      p00_r   <= Q30_ONE;
      p01_r   <= '0;
      p10_r   <= '0;
      p11_r   <= Q30_ONE;
    end else if (cmd.wb) begin
      unique case (cmd.op)
        OP_ANG:  angle_r <= sat32(SUM_W'(angle_r) + m);
        OP_P00:  p00_r   <= sat32(SUM_W'(p00_r) + m);
        OP_P01:  begin
          p01_r <= sat32(SUM_W'(p01_r) + m);
          p10_r <= sat32(SUM_W'(p10_r) + m);
        end
        OP_P11:  p11_r   <= sat32(SUM_W'(p11_r) + m);
        OP_C00:  p00_r   <= sat32(SUM_W'(p00_r) - m);
        OP_C01:  p01_r   <= sat32(SUM_W'(p01_r) - m);
        OP_C10:  p10_r   <= sat32(SUM_W'(p10_r) - m);
        OP_C11:  p11_r   <= sat32(SUM_W'(p11_r) - m);
        OP_AE:   angle_r <= sat32(SUM_W'(angle_r) + m);
        OP_BE:   bias_r  <= sat32(SUM_W'(bias_r) + m);
        default: ;
      endcase
    end
  end

  assign status.div_last = (cnt_r == '0);
  assign out_tdata       = {out_rate_r, out_ang_r};

  // Nonpositive denominator gives a zero gain
  a_zero_gain: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.div_wb && !cmd.div_sel && dzero_r |=> k0_r == '0)
    else $error("gain not zero for nonpositive denominator");

endmodule

### rtl/core/tak_ctrl.sv
module tak_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_tvalid,
  output logic          in_tready,
  output logic          out_tvalid,
  input  logic          out_tready,
  input  tak_pkg::status_t status,
  output tak_pkg::cmd_t cmd
);
  import tak_pkg::*;

  state_t state_r, state_nxt;
  op_t    op_r, op_nxt;
  logic   sel_r, sel_nxt;
  logic   out_valid_r;

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      op_r        <= OP_ANG;
      sel_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      op_r    <= op_nxt;
      sel_r   <= sel_nxt;
      if (cmd.fin)         out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  // Sequencer
  always_comb begin
    state_nxt   = state_r;
    op_nxt      = op_r;
    sel_nxt     = sel_r;
    cmd         = '0;
    cmd.op      = op_r;
    cmd.div_sel = sel_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          cmd.load_in = 1'b1;
          op_nxt      = OP_ANG;
          state_nxt   = S_LD;
        end
      end
      S_LD: begin
        cmd.ld    = 1'b1;
        state_nxt = S_MUL;
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_WB;
      end
      S_WB: begin
        cmd.wb = 1'b1;
        priority if (op_r == OP_P11) state_nxt = S_PREP;
        else if (op_r == OP_BE)      state_nxt = S_FIN;
        else begin
          op_nxt    = op_t'(op_r + 4'd1);
          state_nxt = S_LD;
        end
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        sel_nxt   = 1'b0;
        state_nxt = S_DIV_INIT;
      end
      S_DIV_INIT: begin
        cmd.div_init = 1'b1;
        state_nxt    = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        cmd.div_step = 1'b1;
        if (status.div_last) state_nxt = S_DIV_END;
      end
      S_DIV_END: begin
        cmd.div_wb = 1'b1;
        if (sel_r) begin
          op_nxt    = OP_C00;
          state_nxt = S_LD;
        end else begin
          sel_nxt   = 1'b1;
          state_nxt = S_DIV_INIT;
        end
      end
      S_FIN: begin
        if (!out_valid_r || out_tready) begin
          cmd.fin   = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = out_valid_r;

  // A result is posted right after the finish step
  a_fin_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.fin |=> out_valid_r)
    else $error("result not posted after finish");

  // An accepted beat starts with the angle prediction
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> state_r == S_LD && op_r == OP_ANG)
    else $error("item did not start with angle prediction");

  // Last divider step hands over to the gain write
  a_div_end: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_DIV_RUN && status.div_last |=> state_r == S_DIV_END)
    else $error("divider overran");

endmodule

### rtl/core/tilt_angle_kalman_filter_core.sv
// Two-state tilt Kalman filter (angle and gyro bias) in fixed point: each
// input beat carries an accelerometer angle and a gyro rate in Q16.16, and
// each produces one output beat with the filtered angle and the
// bias-corrected rate. Noises and time step are Q2.30 APB registers at
// byte addresses 0, 4, 8 and 12. They are to be written only while the
// block is idle; the block itself does not enforce this. An item makes
// ten passes through the shared multiplier (load, multiply, write-back)
// and two 32-step restoring divisions for the gains, plus set-up steps.
// Input is taken one item at a time; the result register lets the next
// item be accepted while a finished result waits.
module tilt_angle_kalman_filter_core (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [63:0] in_tdata,    // [31:0] accel_angle, [63:32] gyro_rate
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,   // [31:0] filtered_angle, [63:32] corrected_rate
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [tak_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);
  import tak_pkg::*;

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  tak_regs u_regs (
    .clk, .rst_n, .cfg_psel, .cfg_penable, .cfg_pwrite, .cfg_paddr,
    .cfg_pwdata, .cfg_prdata, .cfg_pready, .cfg
  );

  tak_ctrl u_ctrl (
    .clk, .rst_n, .in_tvalid, .in_tready, .out_tvalid, .out_tready,
    .status, .cmd
  );

  tak_dp u_dp (
    .clk, .rst_n, .cmd, .cfg, .in_tdata, .status, .out_tdata
  );

endmodule
